@@ design/pcm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and pipeline types for the pointwise convolution MAC engine.
// No dependencies; the interfaces, the cell, the core and the bench import this package.
package pcm_pkg;

    // Array sizes.
    localparam int MAX_OUT_CH = 16;
    localparam int MAX_IN_CH  = 64;

    // Field widths of the request and result channels.
    localparam int ACTION_W   = 2;
    localparam int OUT_IDX_W  = 4;
    localparam int IN_IDX_W   = 6;
    localparam int SAMPLE_W   = 16;
    localparam int PRESET_W   = 32;
    localparam int RESULT_W   = 32;

    // Internal arithmetic widths.
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = 40;

    // Configuration register widths and port sizes.
    localparam int IN_CNT_W   = 7;
    localparam int OUT_CNT_W  = 5;
    localparam int PIX_W      = 25;
    localparam int PIX_CNT_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // Derived index widths.
    localparam int CH_ADDR_W  = $clog2(MAX_IN_CH);
    localparam int CELL_IDX_W = $clog2(MAX_OUT_CH);

    // Register reset values and limits.
    localparam logic [IN_CNT_W-1:0]  IN_CH_RESET  = IN_CNT_W'(64);
    localparam logic [OUT_CNT_W-1:0] OUT_CH_RESET = OUT_CNT_W'(16);
    localparam logic [PIX_W-1:0]     PIX_RESET    = PIX_W'(65536);
    localparam logic [PIX_W-1:0]     PIX_LIMIT    = PIX_W'(16777216);

    // Accumulator saturation bounds.
    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Result saturation bounds.
    localparam logic [RESULT_W-1:0] RES_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
    localparam logic [RESULT_W-1:0] RES_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

    // Request action codes.
    localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PRESET = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CHANNELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS       = 2'd2;

    // One pipeline stage of the accumulate path, broadcast to every cell.
    typedef struct packed {
        logic                 valid;
        logic                 preset;
        logic                 mac;
        logic                 last;
        logic                 frame;
        logic [OUT_IDX_W-1:0] index;
        logic [PRESET_W-1:0]  preset_value;
    } t_stage;

endpackage

@@ design/pcm_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result streams.
// Depends on pcm_pkg for the field widths.
interface pcm_in_if;
    import pcm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [OUT_IDX_W-1:0] out_index;
    logic [IN_IDX_W-1:0]  in_index;
    logic [SAMPLE_W-1:0]  sample;
    logic [PRESET_W-1:0]  preset_value;

    modport source (output valid, action, out_index, in_index, sample, preset_value,
                    input ready);
    modport sink   (input valid, action, out_index, in_index, sample, preset_value,
                    output ready);
endinterface

interface pcm_out_if;
    import pcm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] result_channel;
    logic [RESULT_W-1:0]  result_value;
    logic                 clipped;
    logic                 run_last;
    logic                 frame_last;

    modport source (output valid, result_channel, result_value, clipped, run_last,
                    frame_last, input ready);
    modport sink   (input valid, result_channel, result_value, clipped, run_last,
                    frame_last, output ready);
endinterface

@@ design/pcm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/pcm_cell.sv @@
`timescale 1ns / 1ps
// One multiply-accumulate cell: the weights of one output channel, its accumulator
// and one slot of the result shift chain. Depends on pcm_pkg and pcm_ram.
module pcm_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [pcm_pkg::CH_ADDR_W-1:0]  i_waddr,
    input  logic [pcm_pkg::SAMPLE_W-1:0]   i_wdata,
    input  logic [pcm_pkg::CH_ADDR_W-1:0]  i_raddr,
    input  logic [pcm_pkg::SAMPLE_W-1:0]   i_sample,
    input  pcm_pkg::t_stage                i_stage,
    input  logic                           i_sel,
    input  logic                           i_active,
    input  logic                           i_shift,
    input  logic [pcm_pkg::ACC_W-1:0]      i_slot_in,
    output logic [pcm_pkg::ACC_W-1:0]      o_slot
);
    import pcm_pkg::*;

    logic [SAMPLE_W-1:0]      w_weight;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         n_acc;
    logic [ACC_W:0]           w_sum;
    logic [ACC_W-1:0]         w_mac;
    logic [ACC_W-1:0]         r_slot;

    // Weight column of this output channel, indexed by input channel.
    pcm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_IN_CH)
    ) u_wram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_raddr (i_raddr),
        .o_rdata (w_weight)
    );

    // Product of activation and weight, registered before the add.
    assign n_prod = $signed(i_sample) * $signed(w_weight);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // Accumulate with saturation to the accumulator range.
    assign w_sum = {r_acc[ACC_W-1], r_acc}
                 + {{(ACC_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_mac = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_mac = w_sum[ACC_W-1:0];
        end
    end

    // Presets overwrite, activations add, and the end of a pixel clears.
    always_comb begin
        n_acc = r_acc;
        if (i_stage.valid && i_stage.preset && i_sel) begin
            n_acc = {{(ACC_W - PRESET_W){i_stage.preset_value[PRESET_W-1]}},
                     i_stage.preset_value};
        end
        if (i_stage.valid && i_stage.mac) begin
            if (i_active) begin
                n_acc = w_mac;
            end
            if (i_stage.last) begin
                n_acc = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Result slot: loaded at the end of a pixel, then shifted towards cell zero.
    always_ff @(posedge i_clk) begin
        if (i_stage.valid && i_stage.mac && i_stage.last) begin
            r_slot <= i_active ? w_mac : r_acc;
        end else if (i_shift) begin
            r_slot <= i_slot_in;
        end
    end

    assign o_slot = r_slot;

endmodule

@@ design/pointwise_conv_mac_engine_core.sv @@
`timescale 1ns / 1ps
// Pointwise convolution MAC engine: a row of MAX_OUT_CH accumulate cells fed by one
// request stream. Weight writes, presets and activations inside a pixel are taken one per
// cycle. The last activation of a pixel passes the weight read and multiply stages
// into the cells' result slots; the results then leave the shift chain through the output
// register one per cycle whenever that register is free. Input is held off from the last
// activation until the chain has drained. Synchronous active-low reset restores the
// register defaults and clears counters, accumulators and the pipeline; the weight store
// is not cleared.
module pointwise_conv_mac_engine_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pcm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    pcm_in_if.sink                          i_in,
    pcm_out_if.source                       o_out
);
    import pcm_pkg::*;

    // Configuration registers and their effective values.
    logic [IN_CNT_W-1:0]  r_in_ch;
    logic [OUT_CNT_W-1:0] r_out_ch;
    logic [PIX_W-1:0]     r_pix;
    logic [IN_CNT_W-1:0]  w_eff_in;
    logic [OUT_CNT_W-1:0] w_eff_out;
    logic [PIX_W-1:0]     w_eff_pix;

    // Request handling.
    logic                 w_in_acc;
    logic                 w_is_sample;
    logic                 w_wr_ok;
    logic [CH_ADDR_W-1:0] r_ch_cnt;
    logic [CH_ADDR_W-1:0] n_ch_cnt;
    logic [PIX_CNT_W-1:0] r_pix_cnt;
    logic [PIX_CNT_W-1:0] n_pix_cnt;
    logic [IN_CNT_W-1:0]  w_ch_next;
    logic [PIX_W-1:0]     w_pix_next;
    logic                 w_pix_end;
    logic                 w_frame_end;

    // Accumulate pipeline.
    t_stage               r_s1;
    t_stage               n_s1;
    t_stage               r_s2;
    logic [SAMPLE_W-1:0]  r_s1_sample;

    // Result drain.
    logic                  r_drain_busy;
    logic                  n_drain_busy;
    logic [CELL_IDX_W-1:0] r_drain_idx;
    logic [CELL_IDX_W-1:0] n_drain_idx;
    logic [CELL_IDX_W-1:0] r_drain_last_idx;
    logic [CELL_IDX_W-1:0] n_drain_last_idx;
    logic                  r_drain_frame;
    logic                  n_drain_frame;
    logic                  w_drain_start;
    logic                  w_take;
    logic                  w_run_last;
    logic [ACC_W-1:0]      w_head;
    logic                  w_head_fits;
    logic [OUT_CNT_W-1:0]  w_last_ch;

    // Output register.
    logic                 r_out_valid;
    logic [OUT_IDX_W-1:0] r_out_channel;
    logic [RESULT_W-1:0]  r_out_value;
    logic                 r_out_clipped;
    logic                 r_out_run_last;
    logic                 r_out_frame_last;

    // Cell wiring.
    logic [ACC_W-1:0]     w_slot [MAX_OUT_CH];

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ch  <= IN_CH_RESET;
            r_out_ch <= OUT_CH_RESET;
            r_pix    <= PIX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IN_CHANNELS:  r_in_ch  <= i_cfg_wdata[IN_CNT_W-1:0];
                CFG_OUT_CHANNELS: r_out_ch <= i_cfg_wdata[OUT_CNT_W-1:0];
                CFG_PIXELS:       r_pix    <= i_cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the registers into their working ranges.
    always_comb begin
        if (r_in_ch == '0) begin
            w_eff_in = IN_CNT_W'(1);
        end else if (r_in_ch > IN_CNT_W'(MAX_IN_CH)) begin
            w_eff_in = IN_CNT_W'(MAX_IN_CH);
        end else begin
            w_eff_in = r_in_ch;
        end

        if (r_out_ch == '0) begin
            w_eff_out = OUT_CNT_W'(1);
        end else if (r_out_ch > OUT_CNT_W'(MAX_OUT_CH)) begin
            w_eff_out = OUT_CNT_W'(MAX_OUT_CH);
        end else begin
            w_eff_out = r_out_ch;
        end

        if (r_pix == '0) begin
            w_eff_pix = PIX_W'(1);
        end else if (r_pix > PIX_LIMIT) begin
            w_eff_pix = PIX_LIMIT;
        end else begin
            w_eff_pix = r_pix;
        end
    end

    // Requests are held off while a pixel end is in flight or results are draining.
    assign i_in.ready = !r_drain_busy && !(r_s1.valid && r_s1.last)
                        && !(r_s2.valid && r_s2.last);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_is_sample = w_in_acc && (i_in.action == ACT_SAMPLE);
    assign w_wr_ok     = w_in_acc && (i_in.action == ACT_WEIGHT)
                         && (IN_CNT_W'(i_in.in_index) < IN_CNT_W'(MAX_IN_CH))
                         && (OUT_CNT_W'(i_in.out_index) < OUT_CNT_W'(MAX_OUT_CH));

    // Channel and pixel counting.
    assign w_ch_next   = IN_CNT_W'(r_ch_cnt) + IN_CNT_W'(1);
    assign w_pix_end   = w_ch_next >= w_eff_in;
    assign w_pix_next  = PIX_W'(r_pix_cnt) + PIX_W'(1);
    assign w_frame_end = w_pix_next >= w_eff_pix;

    always_comb begin
        n_ch_cnt  = r_ch_cnt;
        n_pix_cnt = r_pix_cnt;
        if (w_is_sample) begin
            if (w_pix_end) begin
                n_ch_cnt  = '0;
                n_pix_cnt = w_frame_end ? '0 : w_pix_next[PIX_CNT_W-1:0];
            end else begin
                n_ch_cnt  = w_ch_next[CH_ADDR_W-1:0];
            end
        end
    end

    // First pipeline stage: the weight read is in flight.
    always_comb begin
        n_s1              = '0;
        n_s1.valid        = w_in_acc && ((i_in.action == ACT_SAMPLE)
                                         || (i_in.action == ACT_PRESET));
        n_s1.preset       = i_in.action == ACT_PRESET;
        n_s1.mac          = i_in.action == ACT_SAMPLE;
        n_s1.last         = (i_in.action == ACT_SAMPLE) && w_pix_end;
        n_s1.frame        = w_frame_end;
        n_s1.index        = i_in.out_index;
        n_s1.preset_value = i_in.preset_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_cnt    <= '0;
            r_pix_cnt   <= '0;
            r_s1        <= '0;
            r_s2        <= '0;
        end else begin
            r_ch_cnt    <= n_ch_cnt;
            r_pix_cnt   <= n_pix_cnt;
            r_s1        <= n_s1;
            r_s2        <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sample <= i_in.sample;
    end

    // The row of cells; each slot takes its neighbour's value during the drain.
    for (genvar c = 0; c < MAX_OUT_CH; c++) begin : g_cell
        logic [ACC_W-1:0] w_slot_in;

        if (c == MAX_OUT_CH - 1) begin : g_tail
            assign w_slot_in = '0;
        end else begin : g_link
            assign w_slot_in = w_slot[c+1];
        end

        pcm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_we      (w_wr_ok && (i_in.out_index == OUT_IDX_W'(c))),
            .i_waddr   (i_in.in_index[CH_ADDR_W-1:0]),
            .i_wdata   (i_in.sample),
            .i_raddr   (r_ch_cnt),
            .i_sample  (r_s1_sample),
            .i_stage   (r_s2),
            .i_sel     (r_s2.index == OUT_IDX_W'(c)),
            .i_active  (OUT_CNT_W'(c) < w_eff_out),
            .i_shift   (w_take),
            .i_slot_in (w_slot_in),
            .o_slot    (w_slot[c])
        );
    end

    // Drain control: one result a cycle whenever the output register is free.
    assign w_drain_start = r_s2.valid && r_s2.mac && r_s2.last;
    assign w_take        = r_drain_busy && (!r_out_valid || o_out.ready);
    assign w_run_last    = r_drain_idx == r_drain_last_idx;
    assign w_last_ch     = w_eff_out - OUT_CNT_W'(1);

    always_comb begin
        n_drain_busy     = r_drain_busy;
        n_drain_idx      = r_drain_idx;
        n_drain_last_idx = r_drain_last_idx;
        n_drain_frame    = r_drain_frame;
        if (w_drain_start) begin
            n_drain_busy     = 1'b1;
            n_drain_idx      = '0;
            n_drain_last_idx = w_last_ch[CELL_IDX_W-1:0];
            n_drain_frame    = r_s2.frame;
        end else if (w_take) begin
            n_drain_idx = r_drain_idx + CELL_IDX_W'(1);
            if (w_run_last) begin
                n_drain_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain_busy     <= 1'b0;
            r_drain_idx      <= '0;
            r_drain_last_idx <= '0;
            r_drain_frame    <= 1'b0;
        end else begin
            r_drain_busy     <= n_drain_busy;
            r_drain_idx      <= n_drain_idx;
            r_drain_last_idx <= n_drain_last_idx;
            r_drain_frame    <= n_drain_frame;
        end
    end

    // Saturate the head of the chain to the result width.
    assign w_head      = w_slot[0];
    assign w_head_fits = (w_head[ACC_W-1:RESULT_W-1] == '0)
                         || (w_head[ACC_W-1:RESULT_W-1] == '1);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_channel    <= OUT_IDX_W'(r_drain_idx);
            r_out_value      <= w_head_fits ? w_head[RESULT_W-1:0]
                                            : (w_head[ACC_W-1] ? RES_MIN : RES_MAX);
            r_out_clipped    <= !w_head_fits;
            r_out_run_last   <= w_run_last;
            r_out_frame_last <= w_run_last && r_drain_frame;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_channel = r_out_channel;
    assign o_out.result_value   = r_out_value;
    assign o_out.clipped        = r_out_clipped;
    assign o_out.run_last       = r_out_run_last;
    assign o_out.frame_last     = r_out_frame_last;

    // A pixel end may only reach the cells once the previous drain has finished.
    a_no_drain_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drain_start |-> !r_drain_busy)
        else $error("pixel end reached the cells while results were still draining");

    // The drain finishes exactly when the last result of the pixel is loaded.
    a_drain_ends_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_drain_busy) |-> (r_out_valid && r_out_run_last))
        else $error("drain ended without presenting the last result of the pixel");

    // Taking the last result of a pixel leaves nothing in the chain.
    a_last_means_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_run_last) |=> !r_drain_busy)
        else $error("results still draining behind the last result of a pixel");

    // Requests stay blocked from a pixel end until its results have drained.
    a_hold_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_is_sample && w_pix_end) |=> !i_in.ready)
        else $error("request accepted while a pixel end was in flight");

endmodule

@@ tb/sv/tb_pointwise_conv_mac_engine_core.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the pointwise convolution MAC engine: directed and random
// requests, a cycle-free predictor of the per-pixel results, and random stalls on both sides.
// Depends on pcm_pkg, the pcm_in_if/pcm_out_if interfaces and pointwise_conv_mac_engine_core.
module tb_pointwise_conv_mac_engine_core;
    import pcm_pkg::*;

    // Action code that the engine must ignore.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int TIMEOUT_NS    = 400000;

    localparam longint ACC_CEIL  = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_FLOOR = -(longint'(1) <<< (ACC_W - 1));
    localparam longint RES_CEIL  = 64'sd2147483647;
    localparam longint RES_FLOOR = -64'sd2147483648;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [OUT_IDX_W-1:0] out_index;
        logic [IN_IDX_W-1:0]  in_index;
        logic [SAMPLE_W-1:0]  sample;
        logic [PRESET_W-1:0]  preset_value;
    } t_conv_req;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] channel;
        logic [RESULT_W-1:0]  value;
        logic                 clipped;
        logic                 run_last;
        logic                 frame_last;
    } t_conv_res;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    pcm_in_if  req_if ();
    pcm_out_if res_if ();

    pointwise_conv_mac_engine_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (req_if),
        .o_out       (res_if)
    );

    // Stimulus and scoreboard storage.
    t_conv_req request_backlog [$];
    t_conv_res pending_results [$];
    int        error_count  = 0;
    logic      req_taken    = 1'b0;
    int        send_gap_pct = 0;
    int        recv_gap_pct = 0;
    int        stall_asks   = 0;
    int        stall_seen   = 0;
    int        stall_left   = 0;

    // Predictor state: configuration copy, weights, accumulators and counters.
    logic [IN_CNT_W-1:0]  cfg_in  = IN_CH_RESET;
    logic [OUT_CNT_W-1:0] cfg_out = OUT_CH_RESET;
    logic [PIX_W-1:0]     cfg_pix = PIX_RESET;
    logic [SAMPLE_W-1:0]  weight_bank [MAX_OUT_CH][MAX_IN_CH];
    longint               acc_bank [MAX_OUT_CH];
    int unsigned          chan_cnt = 0;
    int unsigned          pix_cnt  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Effective register values after clamping to the supported range.
    function automatic int unsigned in_span();
        if (cfg_in == 0) return 1;
        if (cfg_in > MAX_IN_CH) return MAX_IN_CH;
        return cfg_in;
    endfunction

    function automatic int unsigned out_span();
        if (cfg_out == 0) return 1;
        if (cfg_out > MAX_OUT_CH) return MAX_OUT_CH;
        return cfg_out;
    endfunction

    function automatic int unsigned frame_span();
        if (cfg_pix == 0) return 1;
        if (cfg_pix > PIX_LIMIT) return PIX_LIMIT;
        return cfg_pix;
    endfunction

    // Applies one accepted request to the predictor and queues any results it completes.
    task automatic fold_request(input t_conv_req r);
        int unsigned nin;
        int unsigned nout;
        longint      sum;
        longint      v;
        logic        frame_end;
        t_conv_res   res;
        case (r.action)
            ACT_WEIGHT: weight_bank[r.out_index][r.in_index] = r.sample;
            ACT_PRESET: acc_bank[r.out_index] = longint'($signed(r.preset_value));
            ACT_SAMPLE: begin
                nin  = in_span();
                nout = out_span();
                if (chan_cnt < MAX_IN_CH) begin
                    for (int c = 0; c < nout; c++) begin
                        sum = acc_bank[c] + longint'($signed(r.sample))
                              * longint'($signed(weight_bank[c][chan_cnt]));
                        if (sum > ACC_CEIL) sum = ACC_CEIL;
                        if (sum < ACC_FLOOR) sum = ACC_FLOOR;
                        acc_bank[c] = sum;
                    end
                end
                chan_cnt++;
                if (chan_cnt >= nin) begin
                    chan_cnt  = 0;
                    pix_cnt++;
                    frame_end = (pix_cnt >= frame_span());
                    if (frame_end) pix_cnt = 0;
                    for (int c = 0; c < nout; c++) begin
                        v           = acc_bank[c];
                        res.clipped = 1'b0;
                        if (v > RES_CEIL) begin
                            v           = RES_CEIL;
                            res.clipped = 1'b1;
                        end
                        if (v < RES_FLOOR) begin
                            v           = RES_FLOOR;
                            res.clipped = 1'b1;
                        end
                        res.channel    = OUT_IDX_W'(c);
                        res.value      = v[RESULT_W-1:0];
                        res.run_last   = (c + 1 == nout);
                        res.frame_last = res.run_last && frame_end;
                        pending_results.push_back(res);
                    end
                    foreach (acc_bank[c]) acc_bank[c] = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            error_count++;
        end
    endtask

    // Monitor: configuration writes, accepted results and accepted requests, all at the
    // rising edge.
    always @(posedge i_clk) begin
        t_conv_res want;
        t_conv_req r;
        if (!i_rst_n) begin
            cfg_in    = IN_CH_RESET;
            cfg_out   = OUT_CH_RESET;
            cfg_pix   = PIX_RESET;
            chan_cnt  = 0;
            pix_cnt   = 0;
            foreach (acc_bank[c]) acc_bank[c] = 0;
            req_taken <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_IN_CHANNELS:  cfg_in  = i_cfg_wdata[IN_CNT_W-1:0];
                    CFG_OUT_CHANNELS: cfg_out = i_cfg_wdata[OUT_CNT_W-1:0];
                    CFG_PIXELS:       cfg_pix = i_cfg_wdata[PIX_W-1:0];
                    default: ;
                endcase
            end
            if (res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual channel %0d value %h",
                             $time, res_if.result_channel, res_if.result_value);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("result_channel", want.channel, res_if.result_channel);
                    check_field("result_value", want.value, res_if.result_value);
                    check_field("clipped", want.clipped, res_if.clipped);
                    check_field("run_last", want.run_last, res_if.run_last);
                    check_field("frame_last", want.frame_last, res_if.frame_last);
                end
            end
            req_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready) begin
                r.action       = req_if.action;
                r.out_index    = req_if.out_index;
                r.in_index     = req_if.in_index;
                r.sample       = req_if.sample;
                r.preset_value = req_if.preset_value;
                fold_request(r);
            end
        end
    end

    // Driver: a request stays offered until taken; new ones are offered with random gaps.
    always @(negedge i_clk) begin
        t_conv_req cur;
        if (!req_if.valid || req_taken) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                cur = request_backlog.pop_front();
                req_if.valid        <= 1'b1;
                req_if.action       <= cur.action;
                req_if.out_index    <= cur.out_index;
                req_if.in_index     <= cur.in_index;
                req_if.sample       <= cur.sample;
                req_if.preset_value <= cur.preset_value;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
    always @(negedge i_clk) begin
        if (stall_seen != stall_asks) begin
            stall_seen = stall_asks;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Request builders; fields that the action does not use are left random.
    function automatic t_conv_req random_req(input logic [ACTION_W-1:0] act);
        t_conv_req r;
        r.action       = act;
        r.out_index    = OUT_IDX_W'($urandom);
        r.in_index     = IN_IDX_W'($urandom);
        r.sample       = SAMPLE_W'($urandom);
        r.preset_value = $urandom;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [PRESET_W-1:0] pick_preset();
        case ($urandom_range(6))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_weight(input int o, input int i, input logic [SAMPLE_W-1:0] w);
        t_conv_req r;
        r = random_req(ACT_WEIGHT);
        r.out_index = OUT_IDX_W'(o);
        r.in_index  = IN_IDX_W'(i);
        r.sample    = w;
        request_backlog.push_back(r);
    endtask

    task automatic queue_preset(input int o, input logic [PRESET_W-1:0] p);
        t_conv_req r;
        r = random_req(ACT_PRESET);
        r.out_index    = OUT_IDX_W'(o);
        r.preset_value = p;
        request_backlog.push_back(r);
    endtask

    task automatic queue_sample(input logic [SAMPLE_W-1:0] a);
        t_conv_req r;
        r = random_req(ACT_SAMPLE);
        r.sample = a;
        request_backlog.push_back(r);
    endtask

    // Mostly whole pixels (optional presets, then one activation per input channel),
    // mixed with stray weight writes, ignored actions and cut-short pixels.
    task automatic queue_pixels(input int budget);
        int made;
        int roll;
        int span;
        int acts;
        made = 0;
        while (made < budget) begin
            span = in_span();
            roll = $urandom_range(99);
            if (roll < 6) begin
                request_backlog.push_back(random_req(ACT_UNUSED));
            end else if (roll < 14) begin
                queue_weight($urandom_range(MAX_OUT_CH - 1), $urandom_range(MAX_IN_CH - 1),
                             pick_sample());
                made++;
            end else begin
                if (roll >= 20) begin
                    repeat ($urandom_range(2)) begin
                        queue_preset($urandom_range(MAX_OUT_CH - 1), pick_preset());
                        made++;
                    end
                end
                acts = (roll < 20) ? $urandom_range(1, span) : span;
                repeat (acts) queue_sample(pick_sample());
                made += acts;
            end
        end
    endtask

    // Waits until every request is taken and every result is in, then lets the pipeline
    // settle so that a register write finds the engine idle.
    task automatic drain();
        while (request_backlog.size() != 0 || req_if.valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_shape(input int nin, input int nout, input int npix);
        set_reg(CFG_IN_CHANNELS, CFG_DATA_W'(nin));
        set_reg(CFG_OUT_CHANNELS, CFG_DATA_W'(nout));
        set_reg(CFG_PIXELS, CFG_DATA_W'(npix));
    endtask

    initial begin
        req_if.valid        = 1'b0;
        req_if.action       = '0;
        req_if.out_index    = '0;
        req_if.in_index     = '0;
        req_if.sample       = '0;
        req_if.preset_value = '0;
        res_if.ready        = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 16;
        recv_gap_pct = 70;

        // Write every weight that the pixels below can read: the first three input
        // channels of every output channel, and every input channel of output channel 0.
        for (int o = 0; o < MAX_OUT_CH; o++) begin
            for (int i = 0; i < MAX_IN_CH; i++) begin
                if (o == 0 || i < 3) queue_weight(o, i, SAMPLE_W'($urandom));
            end
        end
        drain();

        // Directed: extreme weights, presets that clip both ways, a preset on an inactive
        // channel and an ignored action.
        set_shape(2, 3, 2);
        queue_weight(0, 0, 16'h8000);
        queue_weight(0, 1, 16'h7FFF);
        queue_weight(1, 0, 16'h7FFF);
        queue_weight(1, 1, 16'h8000);
        queue_weight(2, 0, 16'h7FFF);
        queue_weight(2, 1, 16'h0000);
        queue_preset(0, 32'h7FFF_FFFF);
        queue_preset(1, 32'h8000_0000);
        queue_preset(15, 32'h1234_5678);
        queue_sample(16'h8000);
        queue_sample(16'h7FFF);
        request_backlog.push_back(random_req(ACT_UNUSED));
        queue_sample(16'h0000);
        queue_sample(16'h0000);
        drain();

        // Directed: start a three-channel pixel and shrink the channel count in its middle
        // by writing it as zero, then more registers written as zero and above their limit.
        set_reg(CFG_IN_CHANNELS, 3);
        queue_sample(pick_sample());
        queue_sample(pick_sample());
        drain();
        set_reg(CFG_IN_CHANNELS, 0);
        queue_sample(pick_sample());
        drain();
        set_reg(CFG_PIXELS, 0);
        set_reg(CFG_OUT_CHANNELS, 0);
        queue_sample(pick_sample());
        drain();
        set_reg(CFG_OUT_CHANNELS, 31);
        queue_sample(pick_sample());
        drain();

        // Random phase, sender mostly busy and receiver mostly stalled.
        set_shape(3, 4, 3);
        queue_pixels(15);
        drain();

        // Random phases with the roles swapped.
        send_gap_pct = 70;
        recv_gap_pct = 16;
        set_shape(1, 16, 25'h1FF_FFFF);
        queue_pixels(8);
        drain();
        set_shape(3, 2, 1);
        queue_pixels(8);
        drain();

        // No idling, with one long receiver hold-off so the engine backs up onto its input.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        set_shape(2, 31, 3);
        queue_pixels(12);
        stall_asks++;
        drain();

        // Largest pixel: the channel count clamps to every input channel.
        set_shape(127, 1, 0);
        queue_preset(0, pick_preset());
        repeat (MAX_IN_CH) queue_sample(pick_sample());
        drain();

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/pcm_pkg.sv
design/pcm_if.sv
design/pcm_ram.sv
design/pcm_cell.sv
design/pointwise_conv_mac_engine_core.sv
tb/sv/tb_pointwise_conv_mac_engine_core.sv
